### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the decoder RTL
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Codes, field widths and the request structs of the tree walk decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

    localparam int SYM_W   = 8;
    localparam int LEN_W   = 6;
    localparam int CODE_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DECODE = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_SYMBOL = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_FULL     = 2'd1,
        ERR_CODE_LONG = 2'd2,
        ERR_MISSING  = 2'd3
    } err_t;

    typedef struct packed {
        kind_t            kind;
        logic [SYM_W-1:0] sym;
        err_t             err;
    } result_t;

    // engine -> result buffer
    typedef struct packed {
        logic    push;
        logic    flush;
        result_t res;
    } buf_req_t;

    // result buffer -> engine
    typedef struct packed {
        logic push_ok;
        logic flush_ok;
        logic pend_valid;
    } buf_stat_t;

endpackage

### sv/htd_node_ram.sv
// ----------------------------------------------------------------------------
// htd_node_ram
// Node table: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module htd_node_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 26
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/htd_result_buf.sv
// ----------------------------------------------------------------------------
// htd_result_buf
// Holds the newest result back until it is known whether it is the last one
// of its request, and drives the output register.
// ----------------------------------------------------------------------------
module htd_result_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  htd_pkg::buf_req_t   req,
    output htd_pkg::buf_stat_t  stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // symbol_out[7:0], error_code[9:8], zero fill
    output logic [1:0]          m_tuser,   // kind
    output logic                m_tlast
);

    logic              pend_valid_reg, pend_valid_next;
    htd_pkg::result_t  pend_res_reg, pend_res_next;
    logic              out_valid_reg, out_valid_next;
    htd_pkg::result_t  out_res_reg, out_res_next;
    logic              out_last_reg, out_last_next;
    logic              out_free;

    assign out_free      = !out_valid_reg || m_tready;
    assign stat.push_ok  = !pend_valid_reg || out_free;
    assign stat.flush_ok = !pend_valid_reg || out_free;
    assign stat.pend_valid = pend_valid_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        if (req.push && stat.push_ok)
        begin
            // older result moves on, it cannot be the last any more
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_res_next   = pend_res_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_res_next   = req.res;
        end
        else if (req.flush && pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_res_next    = pend_res_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_res_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_res_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_res_reg   <= pend_res_next;
            out_valid_reg  <= out_valid_next;
            out_res_reg    <= out_res_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.err, out_res_reg.sym};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_last_reg;

endmodule

### sv/htd_engine.sv
// ----------------------------------------------------------------------------
// htd_engine
// Sequencer for code insertion and the bit by bit tree walk. The root node
// lives in flip-flops; all other nodes live in the node table.
// ----------------------------------------------------------------------------
module htd_engine #(
    parameter int NODE_SLOTS    = 512,
    parameter int MAX_CODE_BITS = 32,
    parameter int IDX_W         = $clog2(NODE_SLOTS),
    parameter int CNT_W         = $clog2(NODE_SLOTS + 1),
    parameter int ENT_W         = 2 * IDX_W + htd_pkg::SYM_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_action,
    input  logic [htd_pkg::SYM_W-1:0]     in_sym,
    input  logic [htd_pkg::LEN_W-1:0]     in_len,
    input  logic [htd_pkg::CODE_W-1:0]    in_code,
    input  logic [htd_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          cfg_valid,
    input  logic [htd_pkg::COUNT_W-1:0]   cfg_data,
    output logic                          ram_we,
    output logic [IDX_W-1:0]              ram_waddr,
    output logic [ENT_W-1:0]              ram_wdata,
    output logic                          ram_re,
    output logic [IDX_W-1:0]              ram_raddr,
    input  logic [ENT_W-1:0]              ram_rdata,
    output htd_pkg::buf_req_t             req,
    input  htd_pkg::buf_stat_t            stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DFETCH,
        S_DSTEP,
        S_DLEAF,
        S_ISTEP,
        S_ILOAD,
        S_INEW,
        S_FLUSH
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                walk_reg, walk_next;
    logic [IDX_W-1:0]                nxt_reg, nxt_next;
    logic [2:0]                      bit_reg, bit_next;
    logic [htd_pkg::BYTE_W-1:0]      byte_reg, byte_next;
    logic [htd_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [htd_pkg::COUNT_W-1:0]     expected_reg, expected_next;
    logic [CNT_W-1:0]                nodes_reg, nodes_next;
    logic [ENT_W-1:0]                root_reg, root_next;
    logic [IDX_W-1:0]                cur_reg, cur_next;
    logic [ENT_W-1:0]                cur_ent_reg, cur_ent_next;
    logic [htd_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [htd_pkg::CODE_W-1:0]      code_reg, code_next;
    logic [htd_pkg::SYM_W-1:0]       sym_reg, sym_next;

    logic [ENT_W-1:0]                dec_ent;
    logic                            dec_bit;
    logic [IDX_W-1:0]                dec_nxt;
    logic                            rd_leaf;
    logic [htd_pkg::LEN_W-1:0]       ins_pos;
    logic                            ins_bit;
    logic [IDX_W-1:0]                ins_link;
    logic [IDX_W-1:0]                new_idx;
    logic                            table_full;
    logic [htd_pkg::COUNT_W-1:0]     count_inc;
    logic [ENT_W-1:0]                linked_ent;

    // entry layout: {sym, right, left}
    assign dec_ent   = (walk_reg == '0) ? root_reg : ram_rdata;
    assign dec_bit   = byte_reg[bit_reg];
    assign dec_nxt   = dec_bit ? dec_ent[2*IDX_W-1:IDX_W] : dec_ent[IDX_W-1:0];
    assign rd_leaf   = (ram_rdata[IDX_W-1:0] == '0) && (ram_rdata[2*IDX_W-1:IDX_W] == '0);

    assign ins_pos   = len_reg - htd_pkg::LEN_W'(1);
    // code bits above bit 31 count as zero
    assign ins_bit   = ins_pos[htd_pkg::LEN_W-1] ? 1'b0 : code_reg[ins_pos[4:0]];
    assign ins_link  = ins_bit ? cur_ent_reg[2*IDX_W-1:IDX_W] : cur_ent_reg[IDX_W-1:0];
    assign new_idx   = nodes_reg[IDX_W-1:0];
    assign table_full = nodes_reg >= CNT_W'(NODE_SLOTS);
    assign count_inc = count_reg + htd_pkg::COUNT_W'(1);
    assign linked_ent = ins_bit ? {cur_ent_reg[ENT_W-1:2*IDX_W], new_idx, cur_ent_reg[IDX_W-1:0]}
                                : {cur_ent_reg[ENT_W-1:IDX_W], new_idx};

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        walk_next     = walk_reg;
        nxt_next      = nxt_reg;
        bit_next      = bit_reg;
        byte_next     = byte_reg;
        count_next    = count_reg;
        expected_next = expected_reg;
        nodes_next    = nodes_reg;
        root_next     = root_reg;
        cur_next      = cur_reg;
        cur_ent_next  = cur_ent_reg;
        len_next      = len_reg;
        code_next     = code_reg;
        sym_next      = sym_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        req           = '0;
        req.res.kind  = htd_pkg::KIND_DONE;
        req.res.err   = htd_pkg::ERR_NONE;

        if (cfg_valid)
        begin
            expected_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (htd_pkg::action_t'(in_action))
                        htd_pkg::ACT_INSERT:
                        begin
                            sym_next  = in_sym;
                            code_next = in_code;
                            len_next  = in_len;
                            if (int'(in_len) > MAX_CODE_BITS)
                            begin
                                req.push     = 1'b1;
                                req.res.kind = htd_pkg::KIND_ERROR;
                                req.res.err  = htd_pkg::ERR_CODE_LONG;
                                state_next   = S_FLUSH;
                            end
                            else
                            begin
                                cur_next     = '0;
                                cur_ent_next = root_reg;
                                state_next   = S_ISTEP;
                            end
                        end
                        htd_pkg::ACT_DECODE:
                        begin
                            byte_next = in_byte;
                            bit_next  = 3'd7;
                            if (count_reg >= expected_reg)
                            begin
                                state_next = S_FLUSH;
                            end
                            else if (walk_reg == '0)
                            begin
                                state_next = S_DSTEP;
                            end
                            else
                            begin
                                state_next = S_DFETCH;
                            end
                        end
                        htd_pkg::ACT_CLEAR:
                        begin
                            nodes_next = CNT_W'(1);
                            walk_next  = '0;
                            count_next = '0;
                            root_next  = '0;
                            req.push   = 1'b1;
                            state_next = S_FLUSH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DFETCH:
            begin
                ram_re     = 1'b1;
                ram_raddr  = walk_reg;
                state_next = S_DSTEP;
            end

            S_DSTEP:
            begin
                if (dec_nxt == '0)
                begin
                    req.push     = 1'b1;
                    req.res.kind = htd_pkg::KIND_ERROR;
                    req.res.err  = htd_pkg::ERR_MISSING;
                    if (stat.push_ok)
                    begin
                        walk_next  = '0;
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = dec_nxt;
                    nxt_next   = dec_nxt;
                    state_next = S_DLEAF;
                end
            end

            S_DLEAF:
            begin
                if (rd_leaf)
                begin
                    req.push     = 1'b1;
                    req.res.kind = htd_pkg::KIND_SYMBOL;
                    req.res.sym  = ram_rdata[ENT_W-1:2*IDX_W];
                    if (stat.push_ok)
                    begin
                        count_next = count_inc;
                        walk_next  = '0;
                        if ((bit_reg == 3'd0) || (count_inc >= expected_reg))
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            bit_next   = bit_reg - 3'd1;
                            state_next = S_DSTEP;
                        end
                    end
                end
                else
                begin
                    walk_next = nxt_reg;
                    if (bit_reg == 3'd0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 3'd1;
                        state_next = S_DSTEP;
                    end
                end
            end

            S_ISTEP:
            begin
                if (len_reg == '0)
                begin
                    req.push = 1'b1;
                    if (stat.push_ok)
                    begin
                        if (cur_reg == '0)
                        begin
                            root_next = {sym_reg, cur_ent_reg[2*IDX_W-1:0]};
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_reg;
                            ram_wdata = {sym_reg, cur_ent_reg[2*IDX_W-1:0]};
                        end
                        state_next = S_FLUSH;
                    end
                end
                else if (ins_link != '0)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = ins_link;
                    cur_next   = ins_link;
                    len_next   = ins_pos;
                    state_next = S_ILOAD;
                end
                else if (table_full)
                begin
                    req.push     = 1'b1;
                    req.res.kind = htd_pkg::KIND_ERROR;
                    req.res.err  = htd_pkg::ERR_FULL;
                    if (stat.push_ok)
                    begin
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    if (cur_reg == '0)
                    begin
                        root_next = linked_ent;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_reg;
                        ram_wdata = linked_ent;
                    end
                    state_next = S_INEW;
                end
            end

            S_ILOAD:
            begin
                cur_ent_next = ram_rdata;
                state_next   = S_ISTEP;
            end

            S_INEW:
            begin
                ram_we       = 1'b1;
                ram_waddr    = new_idx;
                ram_wdata    = '0;
                cur_next     = new_idx;
                cur_ent_next = '0;
                nodes_next   = nodes_reg + CNT_W'(1);
                len_next     = ins_pos;
                state_next   = S_ISTEP;
            end

            S_FLUSH:
            begin
                req.flush = 1'b1;
                if (stat.flush_ok)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            walk_reg     <= '0;
            nxt_reg      <= '0;
            bit_reg      <= '0;
            byte_reg     <= '0;
            count_reg    <= '0;
            expected_reg <= '0;
            nodes_reg    <= CNT_W'(1);
            root_reg     <= '0;
            cur_reg      <= '0;
            cur_ent_reg  <= '0;
            len_reg      <= '0;
            code_reg     <= '0;
            sym_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_reg     <= walk_next;
            nxt_reg      <= nxt_next;
            bit_reg      <= bit_next;
            byte_reg     <= byte_next;
            count_reg    <= count_next;
            expected_reg <= expected_next;
            nodes_reg    <= nodes_next;
            root_reg     <= root_next;
            cur_reg      <= cur_next;
            cur_ent_reg  <= cur_ent_next;
            len_reg      <= len_next;
            code_reg     <= code_next;
            sym_reg      <= sym_next;
        end
    end

endmodule

### sv/huffman_tree_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Decode byte: accept, fetch the current node if the walk is mid-tree, then a
//   node table read per bit (read data registered), then a flush.
// Insert: per code bit a node table read, or a link write and a new node write, then a flush.
// Clear, code too long: accept, then flush; unused action: accept only. Output stalls make the engine wait.
// Reset (rst_n low, async): empty tree, walk at root, counters and
//   symbols_expected zero; node table contents are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_tree_decoder #(
    parameter int NODE_SLOTS    = 512,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // symbol_in[7:0], code_length[13:8],
                                   // code_value[45:14], data_byte[53:46], zero fill
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // symbol_out[7:0], error_code[9:8], zero fill
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // symbols_expected
);

    localparam int IDX_W = $clog2(NODE_SLOTS);
    localparam int CNT_W = $clog2(NODE_SLOTS + 1);
    localparam int ENT_W = 2 * IDX_W + htd_pkg::SYM_W;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;
    htd_pkg::buf_req_t  buf_req;
    htd_pkg::buf_stat_t buf_stat;

    assign cfg_ready = 1'b1;

    htd_engine #(
        .NODE_SLOTS    (NODE_SLOTS),
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W),
        .ENT_W         (ENT_W)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_sym    (s_tdata[7:0]),
        .in_len    (s_tdata[13:8]),
        .in_code   (s_tdata[45:14]),
        .in_byte   (s_tdata[53:46]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .req       (buf_req),
        .stat      (buf_stat)
    );

    htd_node_ram #(
        .DEPTH  (NODE_SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (ENT_W)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    htd_result_buf u_result_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (buf_req),
        .stat     (buf_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a new request only starts once the previous one has no result held back
    `ASSERT_SAME(a_accept_no_pending, s_tvalid && s_tready, !buf_stat.pend_valid,
        "request accepted with a result still held back")

    // done and error results always close their request
    `ASSERT_SAME(a_nonsym_last, m_tvalid && (m_tuser != htd_pkg::KIND_SYMBOL), m_tlast,
        "done or error result not marked last")

    // decoded symbols carry no error code
    `ASSERT_SAME(a_sym_no_err, m_tvalid && (m_tuser == htd_pkg::KIND_SYMBOL),
        m_tdata[9:8] == htd_pkg::ERR_NONE, "symbol result with error code")

    // node table is never written and read in the same cycle
    `ASSERT_SAME(a_ram_port, ram_we, !ram_re, "node table written and read together")

endmodule

### tb/htd_checker.sv
// ----------------------------------------------------------------------------
// htd_checker
// Watches the request, result and quota channels of the tree walk decoder.
// Keeps its own node table, walk position and symbol count, predicts the
// results of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module htd_checker
    import htd_pkg::*;
#(
    parameter int NODE_SLOTS    = 512,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // symbol_in[7:0], code_length[13:8],
                                   // code_value[45:14], data_byte[53:46], zero fill
    input  logic [1:0]  s_tuser,   // action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // symbol_out[7:0], error_code[9:8], zero fill
    input  logic [1:0]  m_tuser,   // kind
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,  // symbols_expected
    output int          outstanding,
    output int          fails,
    output int          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W      = $clog2(NODE_SLOTS);
    localparam int REPORT_MAX = 10;

    typedef struct {
        kind_t            kind;
        logic [SYM_W-1:0] sym;
        err_t             err;
        logic             last;
    } tree_result_t;

    logic [IDX_W-1:0]   lchild   [NODE_SLOTS];
    logic [IDX_W-1:0]   rchild   [NODE_SLOTS];
    logic [SYM_W-1:0]   node_sym [NODE_SLOTS];
    logic [IDX_W:0]     nodes_used;
    logic [IDX_W-1:0]   walk_node;
    logic [COUNT_W-1:0] decoded_count;
    logic [COUNT_W-1:0] symbols_expected;
    tree_result_t       due_results[$];

    task automatic clear_tree();
        int i;
        for (i = 0; i < NODE_SLOTS; i++)
        begin
            lchild[i]   = '0;
            rchild[i]   = '0;
            node_sym[i] = '0;
        end
        nodes_used    = (IDX_W + 1)'(1);
        walk_node     = '0;
        decoded_count = '0;
    endtask

    task automatic due_push(input kind_t kind, input logic [SYM_W-1:0] sym, input err_t err);
        tree_result_t r;
        r.kind = kind;
        r.sym  = sym;
        r.err  = err;
        r.last = 1'b0;
        due_results.insert(due_results.size(), r);
    endtask

    // builds the path MSB first, allocating nodes as needed
    task automatic insert_path(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                               input logic [CODE_W-1:0] code, output err_t err);
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] nxt;
        logic             branch;
        int               pos;
        cur = '0;
        err = ERR_NONE;
        if (len > MAX_CODE_BITS)
        begin
            err = ERR_CODE_LONG;
            return;
        end
        for (pos = int'(len) - 1; pos >= 0; pos--)
        begin
            branch = (pos < CODE_W) ? code[pos] : 1'b0;
            nxt = branch ? rchild[cur] : lchild[cur];
            if (nxt == '0)
            begin
                if (nodes_used >= NODE_SLOTS)
                begin
                    err = ERR_FULL;
                    return;
                end
                nxt = nodes_used[IDX_W-1:0];
                nodes_used++;
                lchild[nxt]   = '0;
                rchild[nxt]   = '0;
                node_sym[nxt] = '0;
                if (branch)
                    rchild[cur] = nxt;
                else
                    lchild[cur] = nxt;
            end
            cur = nxt;
        end
        node_sym[cur] = sym;
    endtask

    task automatic walk_byte(input logic [BYTE_W-1:0] data);
        logic [IDX_W-1:0] nxt;
        int               b;
        int               first;
        first = due_results.size();
        for (b = BYTE_W - 1; b >= 0 && decoded_count < symbols_expected; b--)
        begin
            nxt = data[b] ? rchild[walk_node] : lchild[walk_node];
            if (nxt == '0)
            begin
                walk_node = '0;
                due_push(KIND_ERROR, '0, ERR_MISSING);
                break;
            end
            if (lchild[nxt] == '0 && rchild[nxt] == '0)
            begin
                due_push(KIND_SYMBOL, node_sym[nxt], ERR_NONE);
                decoded_count++;
                walk_node = '0;
            end
            else
                walk_node = nxt;
        end
        if (due_results.size() > first)
            due_results[$].last = 1'b1;
    endtask

    task automatic predict_request();
        err_t err;
        case (action_t'(s_tuser))
            ACT_INSERT:
            begin
                insert_path(s_tdata[7:0], s_tdata[13:8], s_tdata[45:14], err);
                due_push((err != ERR_NONE) ? KIND_ERROR : KIND_DONE, '0, err);
                due_results[$].last = 1'b1;
            end
            ACT_DECODE:
                walk_byte(s_tdata[53:46]);
            ACT_CLEAR:
            begin
                clear_tree();
                due_push(KIND_DONE, '0, ERR_NONE);
                due_results[$].last = 1'b1;
            end
            default: ;  // unused action code: no result
        endcase
    endtask

    task automatic check_result();
        tree_result_t want;
        checked++;
        if (due_results.size() == 0)
        begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("%t unexpected result: kind %0d sym %02h err %0d last %0b",
                         $realtime, m_tuser, m_tdata[7:0], m_tdata[9:8], m_tlast);
            return;
        end
        want = due_results.pop_front();
        if (m_tuser != want.kind || m_tdata[7:0] != want.sym || m_tdata[9:8] != want.err ||
            m_tlast != want.last || m_tdata[15:10] != '0)
        begin
            fails++;
            if (fails <= REPORT_MAX)
                $display({"%t mismatch: exp kind %0d sym %02h err %0d last %0b, ",
                          "got %0d %02h %0d %0b (fill %02h)"},
                         $realtime, want.kind, want.sym, want.err, want.last,
                         m_tuser, m_tdata[7:0], m_tdata[9:8], m_tlast, m_tdata[15:10]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tree();
            symbols_expected = '0;
            due_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                symbols_expected = cfg_data;
            if (s_tvalid && s_tready)
                predict_request();
            if (m_tvalid && m_tready)
                check_result();
            outstanding = due_results.size();
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives huffman_tree_decoder with directed code inserts and byte decodes,
// then random prefix codes decoded from random bytes under several symbol
// quotas and idling mixes. Results are checked by htd_checker.
// ----------------------------------------------------------------------------
module tb;
    import htd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NODE_SLOTS    = 512;
    localparam int          MAX_CODE_BITS = 32;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          PHASE_REQS    = 10;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;
    localparam logic [31:0] QUOTA_MAX     = 32'hFFFF_FFFF;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;   // symbol_in[7:0], code_length[13:8],
                                   // code_value[45:14], data_byte[53:46], zero fill
    logic [1:0]  s_tuser   = '0;   // action
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // symbol_out[7:0], error_code[9:8], zero fill
    logic [1:0]  m_tuser;          // kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;   // symbols_expected

    int outstanding;
    int fails;
    int checked;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    int requests_sent = 0;
    int quota_writes  = 0;

    huffman_tree_decoder #(
        .NODE_SLOTS    (NODE_SLOTS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    htd_checker #(
        .NODE_SLOTS    (NODE_SLOTS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fails       (fails),
        .checked     (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // run ends if no channel moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results awaited",
                     quiet_cycles, outstanding);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_req(input logic [1:0] act, input logic [7:0] sym,
                            input logic [5:0] len, input logic [31:0] code,
                            input logic [7:0] data);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, data, code, len, sym};
        do
            @(posedge clk);
        while (!s_tready);
        if (act != ACT_UNUSED)
            requests_sent++;
    endtask

    task automatic send_insert(input logic [7:0] sym, input logic [5:0] len,
                               input logic [31:0] code);
        send_req(ACT_INSERT, sym, len, code, 8'($urandom));
    endtask

    task automatic send_decode(input logic [7:0] data);
        send_req(ACT_DECODE, 8'($urandom), 6'($urandom), $urandom, data);
    endtask

    task automatic send_clear();
        send_req(ACT_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic send_noise();
        send_req(2'($urandom_range(ACT_INSERT, ACT_UNUSED)), 8'($urandom), 6'($urandom),
                 $urandom, 8'($urandom));
    endtask

    // hold requests until every result is back and the engine has gone quiet
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_quota(input logic [31:0] quota);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= quota;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        quota_writes++;
    endtask

    // random prefix code by leaf splitting; skewed gives one long chain of ones
    task automatic run_episode(input int max_len, input bit skewed);
        logic [31:0] codes[$];
        int          lens[$];
        logic [31:0] c;
        int          want;
        int          j;
        int          k;
        int          tries;
        send_clear();
        codes = '{32'd0};
        lens  = '{0};
        want  = skewed ? max_len + 1 : $urandom_range(2, 12);
        tries = 0;
        while (codes.size() < want && tries < 100)
        begin
            j = skewed ? codes.size() - 1 : $urandom_range(0, codes.size() - 1);
            if (lens[j] < max_len)
            begin
                c = codes[j] << 1;
                codes[j] = c;
                lens[j]  = lens[j] + 1;
                codes.push_back(c | 32'd1);
                lens.push_back(lens[j]);
            end
            tries++;
        end
        for (k = 0; k < codes.size(); k++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_noise();
            // the odd dropped entry leaves a hole for the walk to fall into
            if ($urandom_range(0, 19) != 0)
                send_insert(8'($urandom), 6'(lens[k]), codes[k] | ($urandom << lens[k]));
        end
        if ($urandom_range(0, 3) == 0)
            wait_drained();
        repeat ($urandom_range(3, 10))
        begin
            if ($urandom_range(0, 15) == 0)
                send_noise();
            send_decode(8'($urandom));
        end
    endtask

    initial
    begin
        int ph;
        int phase_start;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // quota still at reset value: decode gives nothing
        send_insert(8'h41, 6'd1, 32'd0);
        send_decode(8'h00);
        set_quota(QUOTA_MAX);

        send_clear();
        send_insert(8'hA5, 6'd0, 32'hFFFF_FFFF);   // symbol on the root
        send_decode(8'hFF);                         // root has no children
        send_clear();
        send_insert(8'h00, 6'd1, 32'hFFFF_FFFE);   // "0", upper bits ignored
        send_insert(8'hFF, 6'd2, 32'd2);            // "10"
        send_insert(8'h5A, 6'd3, 32'd6);            // "110", "111" left open
        send_decode(8'h00);                         // eight symbols from one byte
        send_decode(8'hB7);                         // two symbols then a hole
        send_decode(8'hDB);                         // ends mid-tree
        send_decode(8'h00);                         // resumes from the saved node
        send_insert(8'h11, 6'd33, 32'd0);
        send_insert(8'h22, 6'd63, 32'hFFFF_FFFF);
        send_insert(8'h77, 6'd32, 32'hFFFF_FFFF);   // deepest path
        repeat (4) send_decode(8'hFF);              // leaf on the last bit only
        send_req(ACT_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        send_insert(8'h12, 6'd1, 32'd1);            // symbol on an inner node
        send_insert(8'h33, 6'd32, 32'd0);           // grows a leaf into a path
        send_decode(8'h00);
        send_clear();

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_quota(QUOTA_MAX);
                1: set_quota($urandom_range(20, 60));
                2: set_quota(32'd3);
                3: set_quota(32'd0);
                default: set_quota(QUOTA_MAX);
            endcase
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            phase_start = requests_sent;
            if (ph == 0)
            begin
                run_episode(MAX_CODE_BITS, 1'b1);
                // long random codes until the node table overflows
                send_clear();
                repeat (24) send_insert(8'($urandom), 6'd32, $urandom);
                repeat (6) send_decode(8'($urandom));
            end
            while (requests_sent - phase_start < PHASE_REQS)
                run_episode($urandom_range(3, 10), 1'b0);
        end

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests under %0d quota settings, %0d results compared",
                 requests_sent, quota_writes, checked);
        $display("inserts, decodes, clears, overflow, long codes and four idling mixes");
        if (fails == 0 && outstanding == 0)
            $display("tb OK");
        else
        begin
            $display("%0d failures, %0d results never arrived", fails, outstanding);
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/htd_pkg.sv
sv/htd_node_ram.sv
sv/htd_result_buf.sv
sv/htd_engine.sv
sv/huffman_tree_decoder.sv
tb/htd_checker.sv
tb/tb.sv
